FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the fractal value noise RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked only out of reset
`define FVN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
// checked on every edge, reset included
`define FVN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FVN_ASSERT(lbl, clk, rstn, prop)
`define FVN_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/fvn_pkg.sv
// ---------------------------------------------------------------------------
// fvn_pkg
// Constants shared by the fractal value noise pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package fvn_pkg;
  localparam int COORD_BITS = 16;
  localparam int OCTAVES    = 7;
  localparam int IN_KEEP    = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam logic [15:0] COORD_MASK = 16'((33'h1 << IN_KEEP) - 33'h1);
  localparam logic [3:0]  TOP_SHIFT  = 4'd8;

  // pipeline stages: 0 corners, 1-5 hash, 6-7 blend, 8 sum / output
  localparam int NST      = 9;
  localparam int OUT_ST   = 8;

  // hash constants
  localparam logic [31:0] H_YMUL = 32'd57;
  localparam logic [31:0] H_MUL  = 32'd15731;
  localparam logic [31:0] H_ADD1 = 32'd789221;
  localparam logic [31:0] H_ADD2 = 32'd1376312589;
  localparam logic [16:0] H_DIV1 = 17'd32767;
  localparam logic [16:0] H_DIV2 = 17'd65534;
  localparam logic [16:0] H_DIV3 = 17'd98301;

  typedef logic [NST-1:0] stage_vec_t;
endpackage
`default_nettype wire

FILE: hdl/fvn_hash.sv
// ---------------------------------------------------------------------------
// fvn_hash
// Five-stage lattice hash: square, polynomial, mask, divide by 0x7fff.
// ---------------------------------------------------------------------------
`default_nettype none
module fvn_hash
  import fvn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [4:0]  en_i,   // enables of pipeline stages 1..5
  input  wire logic [31:0] n_i,
  output logic      [15:0] h_o
);
  logic [31:0] nn_r, n1_r, p_r, n2_r;
  logic [30:0] t_r;
  logic [15:0] a_r;
  logic [16:0] s_r;
  logic [15:0] h_r;
  logic [31:0] t_full;
  logic [1:0]  q_fix;

  // square of the mixed index
  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      nn_r <= n_i * n_i;
      n1_r <= n_i;
    end
  end

  // polynomial inner term
  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      p_r  <= nn_r * H_MUL + H_ADD1;
      n2_r <= n1_r;
    end
  end

  // outer multiply and mask to 31 bits
  assign t_full = n2_r * p_r + H_ADD2;
  always_ff @(posedge clk) begin
    if (en_i[2]) begin
      t_r <= t_full[30:0];
    end
  end

  // t = a*32767 + (a + r), with a = t >> 15 and r = t mod 2^15
  always_ff @(posedge clk) begin
    if (en_i[3]) begin
      a_r <= t_r[30:15];
      s_r <= 17'(t_r[30:15]) + 17'(t_r[14:0]);
    end
  end

  // small correction, quotient wraps to 16 bits
  always_comb begin
    if (s_r >= H_DIV3) begin
      q_fix = 2'd3;
    end else if (s_r >= H_DIV2) begin
      q_fix = 2'd2;
    end else if (s_r >= H_DIV1) begin
      q_fix = 2'd1;
    end else begin
      q_fix = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[4]) begin
      h_r <= a_r + 16'(q_fix);
    end
  end

  assign h_o = h_r;
endmodule
`default_nettype wire

FILE: hdl/fvn_octave.sv
// ---------------------------------------------------------------------------
// fvn_octave
// One octave: corner indices, four hash pipes, bilinear blend, scaling.
// ---------------------------------------------------------------------------
`default_nettype none
module fvn_octave
  import fvn_pkg::*;
(
  input  wire logic        clk,
  input  wire stage_vec_t  en_i,
  input  wire logic [3:0]  idx_i,    // octave index, fixed per instance
  input  wire logic [15:0] x_i,
  input  wire logic [15:0] y_i,
  output logic      [15:0] val_o
);
  logic [3:0]  k;
  logic [8:0]  step;
  logic [31:0] cx, cy, cx1, cy1;
  logic [31:0] n_nxt [4];
  logic [31:0] n_r   [4];
  logic [15:0] h     [4];
  logic [8:0]  fx_r, fy_r;
  logic [8:0]  fx_d [1:5];
  logic [8:0]  fy_d [1:5];
  logic [8:0]  fx6_r;
  logic [25:0] left_r, right_r;
  logic [31:0] mix_r;
  logic [34:0] mix_nxt;
  logic [31:0] mix_sh;

  assign k    = TOP_SHIFT - idx_i;
  assign step = 9'(9'd1 << k);
  assign cx   = 32'(x_i) >> k;
  assign cy   = 32'(y_i) >> k;
  assign cx1  = cx + 32'd1;
  assign cy1  = cy + 32'd1;

  // corner order: 00, 10, 11, 01
  always_comb begin
    logic [31:0] m [4];
    m[0] = cx  + cy  * H_YMUL;
    m[1] = cx1 + cy  * H_YMUL;
    m[2] = cx1 + cy1 * H_YMUL;
    m[3] = cx  + cy1 * H_YMUL;
    for (int c = 0; c < 4; c++) begin
      n_nxt[c] = (m[c] << 13) ^ m[c];
    end
  end

  // stage 0: corner indices and fractions
  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      for (int c = 0; c < 4; c++) begin
        n_r[c] <= n_nxt[c];
      end
      fx_r <= 9'(32'(x_i) - (cx << k));
      fy_r <= 9'(32'(y_i) - (cy << k));
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_hash
    fvn_hash u_hash (
      .clk  (clk),
      .en_i (en_i[5:1]),
      .n_i  (n_r[c]),
      .h_o  (h[c])
    );
  end

  // fractions ride alongside the hash pipes
  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      fx_d[1] <= fx_r;
      fy_d[1] <= fy_r;
    end
    for (int j = 2; j <= 5; j++) begin
      if (en_i[j]) begin
        fx_d[j] <= fx_d[j-1];
        fy_d[j] <= fy_d[j-1];
      end
    end
  end

  // vertical blend
  always_ff @(posedge clk) begin
    if (en_i[6]) begin
      left_r  <= 26'(fy_d[5] * h[3]) + 26'((step - fy_d[5]) * h[0]);
      right_r <= 26'(fy_d[5] * h[2]) + 26'((step - fy_d[5]) * h[1]);
      fx6_r   <= fx_d[5];
    end
  end

  // horizontal blend, never exceeds 32 bits
  assign mix_nxt = 35'(right_r * fx6_r) + 35'(left_r * (step - fx6_r));
  always_ff @(posedge clk) begin
    if (en_i[7]) begin
      mix_r <= mix_nxt[31:0];
    end
  end

  // normalise and weight
  assign mix_sh = mix_r >> {k, 1'b0};
  assign val_o  = mix_sh[15:0] >> (idx_i + 4'd1);
endmodule
`default_nettype wire

FILE: hdl/fractal_value_noise_unit.sv
// ---------------------------------------------------------------------------
// fractal_value_noise_unit
// Seven-octave value noise height from a coordinate pair, fully pipelined.
// ---------------------------------------------------------------------------
// an accepted item passes stages 0 to 8 in order; out_tvalid is the stage 8 valid bit
// throughput: one item per cycle unless out_tready stalls the nine-stage pipeline
// each stage holds back only while full and its successor is blocked
// reset clears all valid bits; payload registers are not reset
`default_nettype none
`include "assert_macros.svh"
module fractal_value_noise_unit
  import fvn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] coord_x, [31:16] coord_y
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata   // [15:0] height
);
  stage_vec_t  v_r, v_nxt, en;
  logic [15:0] x_m, y_m;
  logic [15:0] oct_val [OCTAVES];
  logic [15:0] sum_nxt;
  logic [15:0] height_r;

  assign x_m = in_tdata[15:0]  & COORD_MASK;
  assign y_m = in_tdata[31:16] & COORD_MASK;

  // stage enables: a stage moves when empty or its successor moves
  always_comb begin
    en[OUT_ST] = !v_r[OUT_ST] || out_tready;
    for (int i = OUT_ST - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  // valid bits
  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_tvalid;
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    fvn_octave u_oct (
      .clk   (clk),
      .en_i  (en),
      .idx_i (4'(o)),
      .x_i   (x_m),
      .y_i   (y_m),
      .val_o (oct_val[o])
    );
  end

  // octave sum, wrapping
  always_comb begin
    sum_nxt = '0;
    for (int o = 0; o < OCTAVES; o++) begin
      sum_nxt = sum_nxt + oct_val[o];
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUT_ST]) begin
      height_r <= sum_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[OUT_ST];
  assign out_tdata  = height_r;

  `FVN_ASSERT(a_accept_fills, clk, rst_n, in_tvalid && in_tready |=> v_r[0])
  `FVN_ASSERT(a_stall_full, clk, rst_n, !in_tready |-> v_r[0] && v_r[1])
  `FVN_ASSERT(a_last_moves, clk, rst_n, v_r[OUT_ST-1] && en[OUT_ST-1] |=> out_tvalid)
  `FVN_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid && v_r == '0)
endmodule
`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for fractal_value_noise_unit: coordinate items are sent
// with random gaps, heights are predicted per octave and compared in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// queue of predicted heights with in-order checking
class height_board;
  logic [15:0] pending[$];
  int unsigned fails;

  function new();
    fails = 0;
  endfunction

  // corner hash on the integer lattice
  static function logic [31:0] corner_hash(logic [31:0] gx, logic [31:0] gy);
    logic [31:0] n;
    logic [31:0] t;
    n = gx + gy * 32'd57;
    n = (n << 13) ^ n;
    t = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
    t = t & 32'h7fffffff;
    return (t / 32'h7fff) & 32'hffff;
  endfunction

  // bilinear blend of one octave
  static function logic [31:0] octave_blend(logic [31:0] x, logic [31:0] y, int k);
    logic [31:0] stp, cx, cy, fx, fy, lft, rgt, mix;
    stp = 32'd1 << k;
    cx = x >> k;
    cy = y >> k;
    fx = x - (cx << k);
    fy = y - (cy << k);
    lft = fy * corner_hash(cx, cy + 1) + (stp - fy) * corner_hash(cx, cy);
    rgt = fy * corner_hash(cx + 1, cy + 1) + (stp - fy) * corner_hash(cx + 1, cy);
    mix = rgt * fx + lft * (stp - fx);
    return (mix >> (2 * k)) & 32'hffff;
  endfunction

  static function logic [15:0] predict_height(logic [15:0] x, logic [15:0] y);
    logic [15:0] acc;
    logic [31:0] v;
    acc = 16'd0;
    for (int i = 0; i < fvn_pkg::OCTAVES; i++) begin
      v = octave_blend({16'd0, x & fvn_pkg::COORD_MASK},
                       {16'd0, y & fvn_pkg::COORD_MASK}, 8 - i);
      acc = acc + 16'(v >> (1 + i));
    end
    return acc;
  endfunction

  function void note_coord(logic [31:0] d);
    pending.push_back(predict_height(d[15:0], d[31:16]));
  endfunction

  function void check_height(logic [15:0] got);
    logic [15:0] exp_h;
    if (pending.size() == 0) begin
      $display("%0t: unexpected height item, actual %h", $realtime, got);
      fails++;
      return;
    end
    exp_h = pending.pop_front();
    if (got !== exp_h) begin
      $display("%0t: height mismatch, expected %h actual %h", $realtime, exp_h, got);
      fails++;
    end
  endfunction
endclass

module tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;   // [15:0] coord_x, [31:16] coord_y
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [15:0] height

  height_board board = new();
  bit          hold_off = 1'b0;
  int unsigned sent = 0;

  fractal_value_noise_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one coordinate item and wait for acceptance
  task automatic send_coord(logic [15:0] x, logic [15:0] y, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
    board.note_coord({y, x});
    sent++;
  endtask

  // stop offering and wait for every expected item
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // result sampling at the edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_height(out_tdata);
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // stimulus
  initial begin
    logic [15:0] xs[8];
    logic [15:0] x, y;
    xs = '{16'h0000, 16'hffff, 16'h00ff, 16'h0100, 16'h7fff, 16'h8000, 16'h0001, 16'hfffe};
    x = 16'd0;
    y = 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // corners of the coordinate range and cell boundaries
    foreach (xs[i]) begin
      send_coord(xs[i], xs[(i + 3) % 8], 1'b0);
      send_coord(xs[i], xs[i], 1'b0);
    end
    send_coord(16'hffff, 16'h0000, 1'b0);
    send_coord(16'h0000, 16'hffff, 1'b0);
    drain();
    // back-pressure: receiver stalls while items keep coming
    hold_off = 1'b1;
    for (int n = 0; n < 40; n++) send_coord(16'($urandom), 16'($urandom), 1'b0);
    drain();
    // random part, mostly scanlines with some scattered points
    for (int n = 0; n < 1200; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = x + 16'd1;
      end
      send_coord(x, y, 1'b1);
      if (n == 600) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("tb: FAIL");
    $finish;
  end
endmodule
